[hdl/trht_pkg.sv]
// Shared types and codes for the touch region hit table.
package trht_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned KeyW   = 8;

  // Item kind codes carried in the func field
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_TOUCH = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CoordW-1:0] corner_a_x;
    logic [CoordW-1:0] corner_a_y;
    logic [CoordW-1:0] corner_b_x;
    logic [CoordW-1:0] corner_b_y;
    logic [KeyW-1:0]   region_code;
    logic [CoordW-1:0] touch_x;
    logic [CoordW-1:0] touch_y;
    logic              touch_press;
  } in_item_t;

  typedef struct packed {
    logic              add_accepted;
    logic              hit;
    logic              fired;
    logic [KeyW-1:0]   hit_code;
    logic [CoordW-1:0] hit_x;
    logic [CoordW-1:0] hit_y;
  } out_item_t;

  typedef struct packed {
    logic [CoordW-1:0] x_lo;
    logic [CoordW-1:0] y_lo;
    logic [CoordW-1:0] x_hi;
    logic [CoordW-1:0] y_hi;
    logic [KeyW-1:0]   key;
  } region_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic x_ge_lo;
    logic x_le_hi;
    logic y_ge_lo;
    logic y_le_hi;
  } cmp_flags_t;

endpackage

[hdl/trht_region_mem.sv]
// Region table storage: one write port, one registered read port.
module trht_region_mem
  import trht_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  region_t          wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output region_t          rdata_o
);

  region_t mem_q [DEPTH];
  region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/trht_cmp_unit.sv]
// Shared compare unit: tests a point against the bounds of one box.
module trht_cmp_unit
  import trht_pkg::*;
(
  input  logic [CoordW-1:0] pt_x_i,
  input  logic [CoordW-1:0] pt_y_i,
  input  region_t           box_i,
  output cmp_flags_t        flags_o
);

  always_comb begin
    flags_o.x_ge_lo = (pt_x_i >= box_i.x_lo);
    flags_o.x_le_hi = (pt_x_i <= box_i.x_hi);
    flags_o.y_ge_lo = (pt_y_i >= box_i.y_lo);
    flags_o.y_le_hi = (pt_y_i <= box_i.y_hi);
  end

endmodule

[hdl/touch_region_hit_table.sv]
// Top level of the touch region hit table: sequencer, result and output registers.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i
//   out     | output    | out_valid_o / out_stall_i  | out_data_o
//   cfg     | input     | cfg_we_i                   | cfg_wdata_i
//
// An add passes from transfer to result through accept, table write and output load.
// A touch reads and tests the stored regions in order up to and including the first
// match (all stored regions on a miss); the single table read port scans one region
// per cycle through the shared compare unit.
// Reset empties the table at once; no clearing pass. A stalled output holds the
// finished result while the next item is accepted and worked on.
module touch_region_hit_table
  import trht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  in_item_t          in_q, in_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              report_q;

  logic              mem_we;
  logic              mem_re;
  region_t           wr_region;
  region_t           rd_region;
  region_t           cmp_box;
  logic [CoordW-1:0] cmp_x;
  logic [CoordW-1:0] cmp_y;
  cmp_flags_t        cmp_flags;
  logic              full;
  logic              issue;
  logic              hit_now;

  trht_region_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_region),
    .re_i    (mem_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_region)
  );

  trht_cmp_unit u_cmp (
    .pt_x_i  (cmp_x),
    .pt_y_i  (cmp_y),
    .box_i   (cmp_box),
    .flags_o (cmp_flags)
  );

  // Operand select: sort corners while adding, test the point while scanning
  always_comb begin
    if (state_q == ST_ADD) begin
      cmp_x       = in_q.corner_a_x;
      cmp_y       = in_q.corner_a_y;
      cmp_box     = '0;
      cmp_box.x_lo = in_q.corner_b_x;
      cmp_box.x_hi = in_q.corner_b_x;
      cmp_box.y_lo = in_q.corner_b_y;
      cmp_box.y_hi = in_q.corner_b_y;
    end else begin
      cmp_x   = in_q.touch_x;
      cmp_y   = in_q.touch_y;
      cmp_box = rd_region;
    end
  end

  always_comb begin
    wr_region.x_lo = cmp_flags.x_ge_lo ? in_q.corner_b_x : in_q.corner_a_x;
    wr_region.x_hi = cmp_flags.x_ge_lo ? in_q.corner_a_x : in_q.corner_b_x;
    wr_region.y_lo = cmp_flags.y_ge_lo ? in_q.corner_b_y : in_q.corner_a_y;
    wr_region.y_hi = cmp_flags.y_ge_lo ? in_q.corner_a_y : in_q.corner_b_y;
    wr_region.key  = in_q.region_code;
  end

  assign full    = (count_q == CNT_W'(TABLE_DEPTH));
  assign issue   = (idx_q < count_q);
  assign hit_now = pend_q & (&cmp_flags);

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = (in_data_i.func == FUNC_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        res_d = '0;
        if (!full) begin
          mem_we             = 1'b1;
          count_d            = count_q + CNT_W'(1);
          res_d.add_accepted = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        // Read the next region while checking the one read last cycle
        if (hit_now || !issue) begin
          res_d       = '0;
          res_d.hit_x = in_q.touch_x;
          res_d.hit_y = in_q.touch_y;
          if (hit_now) begin
            res_d.hit      = 1'b1;
            res_d.fired    = in_q.touch_press & report_q;
            res_d.hit_code = rd_region.key;
          end
          state_d = ST_FIN;
        end else begin
          mem_re = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
          pend_d = 1'b1;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      report_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      if (cfg_we_i) begin
        report_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("region count beyond table depth");

  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before item finished");

  a_miss_code_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |-> (out_data_o.hit_code == '0 && !out_data_o.fired))
    else $error("miss result carries code or fire");

  a_add_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.add_accepted) |-> !out_data_o.hit)
    else $error("add result flagged as hit");

endmodule
